@@ hdl/altok_pkg.sv @@
// Shared types, token codes and keyword tables for the assembly line tokenizer.
`timescale 1ns / 1ps

package altok_pkg;

    // Default line width in columns
    localparam int LINE_COLS_DEF = 256;

    // Token kinds
    localparam logic [3:0] KIND_NUMBER   = 4'd0;
    localparam logic [3:0] KIND_REGISTER = 4'd1;
    localparam logic [3:0] KIND_ADD      = 4'd2;
    localparam logic [3:0] KIND_DIV      = 4'd3;
    localparam logic [3:0] KIND_INC      = 4'd4;
    localparam logic [3:0] KIND_MUL      = 4'd5;
    localparam logic [3:0] KIND_WRITE    = 4'd6;
    localparam logic [3:0] KIND_LABEL    = 4'd7;
    localparam logic [3:0] KIND_EQUAL    = 4'd8;
    localparam logic [3:0] KIND_RBRACKET = 4'd9;
    localparam logic [3:0] KIND_LBRACKET = 4'd10;
    localparam logic [3:0] KIND_AT       = 4'd11;
    localparam logic [3:0] KIND_DOLLAR   = 4'd12;
    localparam logic [3:0] KIND_COMMA    = 4'd13;
    localparam logic [3:0] KIND_ERROR    = 4'd14;
    localparam logic [3:0] KIND_EOL      = 4'd15;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_NEWLINE  = 8'h0a;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_SPACE    = " ";
    localparam logic [7:0] CH_SEMI     = ";";
    localparam logic [7:0] CH_EQUAL    = "=";
    localparam logic [7:0] CH_RBRACKET = "]";
    localparam logic [7:0] CH_LBRACKET = "[";
    localparam logic [7:0] CH_AT       = "@";
    localparam logic [7:0] CH_DOLLAR   = "$";
    localparam logic [7:0] CH_COMMA    = ",";
    localparam logic [7:0] CH_UNDER    = "_";
    localparam logic [7:0] CH_REG      = "R";

    // Keyword tables: ADD DIV INC MUL WRITE
    localparam int NUM_KW = 5;
    localparam logic [7:0] KW_FIRST [NUM_KW] = '{"A", "D", "I", "M", "W"};
    localparam logic [7:0] KW_REST [NUM_KW][4] = '{
        '{"D", "D", 8'h00, 8'h00},
        '{"I", "V", 8'h00, 8'h00},
        '{"N", "C", 8'h00, 8'h00},
        '{"U", "L", 8'h00, 8'h00},
        '{"R", "I", "T", "E"}
    };
    localparam logic [7:0] KW_REST_LEN [NUM_KW] = '{8'd2, 8'd2, 8'd2, 8'd2, 8'd4};
    localparam logic [3:0] KW_KIND [NUM_KW] =
        '{KIND_ADD, KIND_DIV, KIND_INC, KIND_MUL, KIND_WRITE};

    // One token as it leaves the block
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] start_col;
        logic [7:0] tok_len;
        logic       last;
    } t_tok;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

endpackage

@@ hdl/altok_if.sv @@
// Request channel interfaces: source bytes in, tokens out.
`timescale 1ns / 1ps

interface altok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface altok_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] start_col;
    logic [7:0] tok_len;
    logic       last;

    modport source (output valid, output kind, output start_col, output tok_len,
                    output last, input ready);
    modport sink   (input valid, input kind, input start_col, input tok_len,
                    input last, output ready);
endinterface

@@ hdl/assembly_line_tokenizer.sv @@
// Top level of the assembly line tokenizer: byte register, scan logic, token queue.
`timescale 1ns / 1ps

// Usage
//   i_src  : one ASCII source byte per request (ch).
//   o_tok  : tokens (kind, start_col, tok_len, last); last marks the final
//            token caused by one source byte. A byte causes zero, one or two
//            tokens: a flushed pending token, then its own token or end of line.
// Path: a byte is held in the byte register, scanned from there, and its
//   tokens are written into the token queue, from which o_tok shows them.
// Throughput: one byte per cycle while each byte causes at most one token
//   and o_tok is taken every cycle. The token queue drains one token a cycle,
//   so a byte that causes two tokens takes up more of the output.
// Stall: the scan stage waits whenever the four-entry token queue has fewer
//   than two free slots; i_src.ready then drops once the byte register is full.
//   The input side still takes a byte while a finished token waits on o_tok.
// Reset (synchronous, active low): the queue empties, the scanner returns to
//   idle between tokens at column 0, and no token is shown.
module assembly_line_tokenizer #(
    parameter int LINE_COLS = altok_pkg::LINE_COLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    altok_in_if.sink           i_src,
    altok_out_if.source        o_tok
);

    localparam logic [7:0] ColMax = (LINE_COLS - 1 < 255) ? 8'(LINE_COLS - 1) : 8'd255;
    localparam int QDepth = 4;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_IDENT,
        MODE_SKIP
    } t_mode;

    // Byte register
    logic       r_in_valid;
    logic [7:0] r_ch;

    // Scanner state
    t_mode      r_mode, n_mode;
    logic [7:0] r_column, n_column;
    logic [7:0] r_pstart, n_pstart;
    logic [7:0] r_plen, n_plen;
    logic [7:0] r_first, n_first;
    logic [4:0] r_hits, n_hits;
    logic       r_sid, n_sid;

    // Token queue
    altok_pkg::t_tok r_q [QDepth];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;

    logic            proc;
    logic            pop;
    logic [1:0]      n_res;
    altok_pkg::t_tok res_first, res_second;

    // Scan stage runs when two queue slots are free
    assign proc = r_in_valid && (r_count <= 3'd2);
    assign pop  = o_tok.valid && o_tok.ready;
    assign i_src.ready = !r_in_valid || proc;

    assign o_tok.valid     = (r_count != 3'd0);
    assign o_tok.kind      = r_q[r_rd_ptr].kind;
    assign o_tok.start_col = r_q[r_rd_ptr].start_col;
    assign o_tok.tok_len   = r_q[r_rd_ptr].tok_len;
    assign o_tok.last      = r_q[r_rd_ptr].last;

    // Scan one byte: state update and up to two tokens
    always_comb begin
        logic       dig, alp, eol, cont, flush, have_b;
        logic [7:0] up, pm1;
        logic [3:0] fkind, bkind;
        logic [7:0] blen;

        dig = altok_pkg::is_digit(r_ch);
        alp = altok_pkg::is_alpha(r_ch);
        eol = (r_ch == altok_pkg::CH_NUL) || (r_ch == altok_pkg::CH_NEWLINE);
        up  = ((r_ch >= "a") && (r_ch <= "z")) ? r_ch - 8'd32 : r_ch;
        pm1 = r_plen - 8'd1;

        n_mode   = r_mode;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        n_first  = r_first;
        n_hits   = r_hits;
        n_sid    = r_sid;
        n_column = eol ? 8'd0 : ((r_column < ColMax) ? r_column + 8'd1 : ColMax);

        have_b = 1'b0;
        bkind  = altok_pkg::KIND_ERROR;
        blen   = 8'd1;

        cont = ((r_mode == MODE_NUM) && dig) ||
               ((r_mode == MODE_IDENT) && (dig || alp || (r_ch == altok_pkg::CH_UNDER)));
        flush = !cont && ((r_mode == MODE_NUM) || (r_mode == MODE_IDENT));

        // Class of the pending token
        fkind = altok_pkg::KIND_LABEL;
        for (int k = altok_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (r_hits[k] && (r_plen == altok_pkg::KW_REST_LEN[k] + 8'd1)) begin
                fkind = altok_pkg::KW_KIND[k];
            end
        end
        if ((r_plen == 8'd2) && (r_first == altok_pkg::CH_REG) && r_sid) begin
            fkind = altok_pkg::KIND_REGISTER;
        end
        if (r_mode == MODE_NUM) begin
            fkind = altok_pkg::KIND_NUMBER;
        end

        if (cont) begin
            // Extend the pending token
            if (r_mode == MODE_IDENT) begin
                if (r_plen == 8'd1) begin
                    n_sid = dig;
                end
                for (int k = 0; k < altok_pkg::NUM_KW; k++) begin
                    if (!((r_plen >= 8'd1) && (pm1 < altok_pkg::KW_REST_LEN[k]) &&
                          (up == altok_pkg::KW_REST[k][pm1[1:0]]))) begin
                        n_hits[k] = 1'b0;
                    end
                end
            end
            n_plen = (r_plen < 8'd255) ? r_plen + 8'd1 : 8'd255;
        end else begin
            if (flush) begin
                n_mode = MODE_IDLE;
                n_plen = 8'd0;
            end
            if (eol) begin
                have_b = 1'b1;
                bkind  = altok_pkg::KIND_EOL;
                blen   = 8'd0;
                n_mode = MODE_IDLE;
            end else if (flush || (r_mode == MODE_IDLE)) begin
                // Byte between tokens
                case (r_ch)
                    altok_pkg::CH_EQUAL: begin
                        have_b = 1'b1;
                        bkind  = altok_pkg::KIND_EQUAL;
                    end
                    altok_pkg::CH_RBRACKET: begin
                        have_b = 1'b1;
                        bkind  = altok_pkg::KIND_RBRACKET;
                    end
                    altok_pkg::CH_LBRACKET: begin
                        have_b = 1'b1;
                        bkind  = altok_pkg::KIND_LBRACKET;
                    end
                    altok_pkg::CH_AT: begin
                        have_b = 1'b1;
                        bkind  = altok_pkg::KIND_AT;
                    end
                    altok_pkg::CH_DOLLAR: begin
                        have_b = 1'b1;
                        bkind  = altok_pkg::KIND_DOLLAR;
                    end
                    altok_pkg::CH_COMMA: begin
                        have_b = 1'b1;
                        bkind  = altok_pkg::KIND_COMMA;
                    end
                    altok_pkg::CH_SPACE, altok_pkg::CH_TAB, altok_pkg::CH_CR: begin
                        have_b = 1'b0;
                    end
                    altok_pkg::CH_SEMI: begin
                        n_mode = MODE_SKIP;
                    end
                    default: begin
                        if (dig) begin
                            n_mode   = MODE_NUM;
                            n_pstart = r_column;
                            n_plen   = 8'd1;
                        end else if (alp) begin
                            n_mode   = MODE_IDENT;
                            n_pstart = r_column;
                            n_plen   = 8'd1;
                            n_first  = r_ch;
                            n_sid    = 1'b0;
                            for (int k = 0; k < altok_pkg::NUM_KW; k++) begin
                                n_hits[k] = (r_ch == altok_pkg::KW_FIRST[k]);
                            end
                        end else begin
                            // Unexpected byte: error, skip rest of line
                            have_b = 1'b1;
                            bkind  = altok_pkg::KIND_ERROR;
                            n_mode = MODE_SKIP;
                        end
                    end
                endcase
            end
        end

        // Order the tokens: flushed one first
        res_second = '{kind: bkind, start_col: r_column, tok_len: blen, last: 1'b1};
        if (flush) begin
            res_first = '{kind: fkind, start_col: r_pstart, tok_len: r_plen,
                          last: !have_b};
            n_res     = have_b ? 2'd2 : 2'd1;
        end else begin
            res_first = res_second;
            n_res     = have_b ? 2'd1 : 2'd0;
        end
    end

    // State, byte register and token queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_column   <= 8'd0;
            r_pstart   <= 8'd0;
            r_plen     <= 8'd0;
            r_first    <= 8'd0;
            r_hits     <= 5'h1f;
            r_sid      <= 1'b0;
            r_wr_ptr   <= 2'd0;
            r_rd_ptr   <= 2'd0;
            r_count    <= 3'd0;
        end else begin
            if (i_src.valid && i_src.ready) begin
                r_in_valid <= 1'b1;
                r_ch       <= i_src.ch;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end

            if (proc) begin
                r_mode   <= n_mode;
                r_column <= n_column;
                r_pstart <= n_pstart;
                r_plen   <= n_plen;
                r_first  <= n_first;
                r_hits   <= n_hits;
                r_sid    <= n_sid;
                if (n_res != 2'd0) begin
                    r_q[r_wr_ptr] <= res_first;
                end
                if (n_res == 2'd2) begin
                    r_q[r_wr_ptr + 2'd1] <= res_second;
                end
                r_wr_ptr <= r_wr_ptr + n_res;
            end

            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + (proc ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
        end
    end

endmodule

@@ hdl/altok_checker.sv @@
// Port-level checker for the assembly line tokenizer, bound to the top level.
`timescale 1ns / 1ps

module altok_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [3:0] i_kind,
    input logic [7:0] i_tok_len
);

    // A shown token stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("token dropped while stalled");

    // End of line carries no length
    a_eol_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == altok_pkg::KIND_EOL) |-> (i_tok_len == 8'd0))
        else $error("end of line with nonzero length");

    // Punctuation and error tokens are one byte long
    a_single_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && ((i_kind == altok_pkg::KIND_EQUAL) || (i_kind == altok_pkg::KIND_RBRACKET) ||
                    (i_kind == altok_pkg::KIND_LBRACKET) || (i_kind == altok_pkg::KIND_AT) ||
                    (i_kind == altok_pkg::KIND_DOLLAR) || (i_kind == altok_pkg::KIND_COMMA) ||
                    (i_kind == altok_pkg::KIND_ERROR))
        |-> (i_tok_len == 8'd1))
        else $error("single-byte token with wrong length");

    // Registers are two bytes long
    a_reg_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == altok_pkg::KIND_REGISTER) |-> (i_tok_len == 8'd2))
        else $error("register token with wrong length");

    // Three-letter keywords have their spelled length
    a_kw_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && ((i_kind == altok_pkg::KIND_ADD) || (i_kind == altok_pkg::KIND_DIV) ||
                    (i_kind == altok_pkg::KIND_INC) || (i_kind == altok_pkg::KIND_MUL))
        |-> (i_tok_len == 8'd3))
        else $error("three-letter keyword with wrong length");

endmodule

bind assembly_line_tokenizer altok_checker u_altok_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_tok.valid),
    .i_ready   (o_tok.ready),
    .i_kind    (o_tok.kind),
    .i_tok_len (o_tok.tok_len)
);

@@ tb/tb_assembly_line_tokenizer.sv @@
// Self-checking testbench for the assembly line tokenizer: byte stream in, tokens checked.
`timescale 1ns / 1ps

module tb_assembly_line_tokenizer;
    import altok_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int TEXT_TARGET   = 1300;
    localparam int TAIL_CALM     = 200;
    localparam int QUIET_LO      = 500;
    localparam int QUIET_HI      = 650;
    localparam int HOLD_AT       = 200;
    localparam int HOLD_CYCLES   = 64;
    localparam int DRAIN_AT      = 800;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [7:0] COL_LIMIT =
        (LINE_COLS_DEF - 1 < 255) ? 8'(LINE_COLS_DEF - 1) : 8'd255;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUM, SCAN_IDENT, SCAN_SKIP} t_scan_mode;

    // One source byte, with its token typed in where it is obvious
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        logic [3:0] kind;
        logic [7:0] col;
        logic [7:0] len;
    } t_text_byte;

    localparam logic [7:0] PUNCT [6] =
        '{CH_EQUAL, CH_RBRACKET, CH_LBRACKET, CH_AT, CH_DOLLAR, CH_COMMA};
    localparam logic [7:0] BLANKS [3] = '{CH_SPACE, CH_TAB, CH_CR};
    localparam logic [7:0] SEPS [4]   = '{CH_SPACE, CH_COMMA, CH_TAB, CH_EQUAL};

    // Directed lines: punctuation, register, keyword, number into identifier,
    // comment, error byte and underscore at token start
    localparam int DIR_ROWS = 27;
    localparam t_text_byte DIRECTED_TEXT [DIR_ROWS] = '{
        '{CH_EQUAL,    1'b1, KIND_EQUAL,    8'd0,  8'd1},
        '{CH_RBRACKET, 1'b1, KIND_RBRACKET, 8'd1,  8'd1},
        '{CH_LBRACKET, 1'b1, KIND_LBRACKET, 8'd2,  8'd1},
        '{CH_AT,       1'b1, KIND_AT,       8'd3,  8'd1},
        '{CH_DOLLAR,   1'b1, KIND_DOLLAR,   8'd4,  8'd1},
        '{CH_COMMA,    1'b1, KIND_COMMA,    8'd5,  8'd1},
        '{CH_NEWLINE,  1'b1, KIND_EOL,      8'd6,  8'd0},
        '{CH_REG,      1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{"9",         1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{CH_TAB,      1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{"M",         1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{"u",         1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{"l",         1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{CH_COMMA,    1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{"0",         1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{"9",         1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{"x",         1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{CH_UNDER,    1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{CH_SEMI,     1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{8'hff,       1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{CH_NUL,      1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{8'hff,       1'b1, KIND_ERROR,    8'd0,  8'd1},
        '{"A",         1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{CH_CR,       1'b0, KIND_NUMBER,   8'd0,  8'd0},
        '{CH_NEWLINE,  1'b1, KIND_EOL,      8'd3,  8'd0},
        '{CH_UNDER,    1'b1, KIND_ERROR,    8'd0,  8'd1},
        '{CH_NEWLINE,  1'b1, KIND_EOL,      8'd1,  8'd0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    altok_in_if  src_if ();
    altok_out_if tok_if ();

    assembly_line_tokenizer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_if),
        .o_tok   (tok_if)
    );

    // Scanner state as the predictor sees it
    t_scan_mode pr_mode       = SCAN_IDLE;
    logic [7:0] pr_col        = 8'd0;
    logic [7:0] pr_start      = 8'd0;
    logic [7:0] pr_len        = 8'd0;
    logic [7:0] pr_first      = 8'd0;
    logic [4:0] pr_hits       = 5'b11111;
    logic       pr_second_num = 1'b0;

    t_tok       byte_tokens [$];
    t_tok       tokens_due [$];
    t_text_byte src_text [$];
    t_text_byte req_now;
    int         src_total    = 0;
    int         accepted_cnt = 0;
    int         mismatch_cnt = 0;
    int         cycle_cnt    = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic logic char_is_num(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic char_is_letter(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hff) ? v : v + 8'd1;
    endfunction

    function automatic void emit(input logic [3:0] kind, input logic [7:0] start,
                                 input logic [7:0] len);
        t_tok t;
        t.kind      = kind;
        t.start_col = start;
        t.tok_len   = len;
        t.last      = 1'b0;
        byte_tokens.push_back(t);
    endfunction

    // Register, keyword or label, from what is left of the running match
    function automatic logic [3:0] ident_kind();
        int k;
        if (pr_len == 8'd2 && pr_first == CH_REG && pr_second_num)
            return KIND_REGISTER;
        for (k = 0; k < NUM_KW; k++)
            if (pr_hits[k] && pr_len == KW_REST_LEN[k] + 8'd1)
                return KW_KIND[k];
        return KIND_LABEL;
    endfunction

    function automatic void flush_pending();
        emit((pr_mode == SCAN_NUM) ? KIND_NUMBER : ident_kind(), pr_start, pr_len);
        pr_mode = SCAN_IDLE;
        pr_len  = 8'd0;
    endfunction

    // Next identifier byte: keyword tail compares without case
    function automatic void ident_grow(input logic [7:0] c);
        int         pos;
        int         k;
        logic [7:0] up;
        logic       keep;
        pos = pr_len;
        up  = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        if (pos == 1)
            pr_second_num = char_is_num(c);
        for (k = 0; k < NUM_KW; k++) begin
            keep = 1'b0;
            if (pos >= 1 && pos - 1 < int'(KW_REST_LEN[k]))
                keep = (up == KW_REST[k][pos - 1]);
            if (!keep)
                pr_hits[k] = 1'b0;
        end
        pr_len = sat_inc(pr_len);
    endfunction

    // Byte seen between tokens
    function automatic void start_token(input logic [7:0] c, input logic [7:0] col);
        int k;
        case (c)
            CH_EQUAL:    emit(KIND_EQUAL, col, 8'd1);
            CH_RBRACKET: emit(KIND_RBRACKET, col, 8'd1);
            CH_LBRACKET: emit(KIND_LBRACKET, col, 8'd1);
            CH_AT:       emit(KIND_AT, col, 8'd1);
            CH_DOLLAR:   emit(KIND_DOLLAR, col, 8'd1);
            CH_COMMA:    emit(KIND_COMMA, col, 8'd1);
            CH_SPACE, CH_TAB, CH_CR: ;
            CH_SEMI:     pr_mode = SCAN_SKIP;
            default: begin
                if (char_is_num(c)) begin
                    pr_mode  = SCAN_NUM;
                    pr_start = col;
                    pr_len   = 8'd1;
                end else if (char_is_letter(c)) begin
                    pr_mode       = SCAN_IDENT;
                    pr_start      = col;
                    pr_len        = 8'd1;
                    pr_first      = c;
                    pr_second_num = 1'b0;
                    pr_hits       = '0;
                    for (k = 0; k < NUM_KW; k++)
                        if (c == KW_FIRST[k])
                            pr_hits[k] = 1'b1;
                end else begin
                    // anything else kills the rest of the line
                    pr_mode = SCAN_SKIP;
                    emit(KIND_ERROR, col, 8'd1);
                end
            end
        endcase
    endfunction

    // Tokens caused by one accepted byte, left in byte_tokens
    function automatic void tokenize_byte(input logic [7:0] c);
        logic [7:0] col;
        logic       eol;
        logic       taken;
        t_tok       t;
        col   = pr_col;
        eol   = (c == CH_NUL) || (c == CH_NEWLINE);
        taken = 1'b0;
        byte_tokens.delete();
        if (pr_mode == SCAN_NUM) begin
            if (char_is_num(c)) begin
                pr_len = sat_inc(pr_len);
                taken  = 1'b1;
            end else begin
                flush_pending();
            end
        end else if (pr_mode == SCAN_IDENT) begin
            if (char_is_num(c) || char_is_letter(c) || c == CH_UNDER) begin
                ident_grow(c);
                taken = 1'b1;
            end else begin
                flush_pending();
            end
        end
        if (!taken) begin
            if (eol) begin
                emit(KIND_EOL, col, 8'd0);
                pr_mode = SCAN_IDLE;
            end else if (pr_mode == SCAN_IDLE) begin
                start_token(c, col);
            end
        end
        pr_col = eol ? 8'd0 : ((col < COL_LIMIT) ? col + 8'd1 : COL_LIMIT);
        if (byte_tokens.size() > 0) begin
            t      = byte_tokens.pop_back();
            t.last = 1'b1;
            byte_tokens.push_back(t);
        end
    endfunction

    // Source text generation
    function automatic void add_ch(input logic [7:0] c);
        t_text_byte r;
        r    = '0;
        r.ch = c;
        src_text.push_back(r);
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = "A" + 8'($urandom_range(0, 25));
        return $urandom_range(0, 1) ? (c | 8'h20) : c;
    endfunction

    function automatic logic [7:0] rand_digit();
        return "0" + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_word_char();
        int pick;
        pick = $urandom_range(0, 37);
        if (pick < 26)
            return rand_letter();
        if (pick < 36)
            return rand_digit();
        return CH_UNDER;
    endfunction

    // Any byte that is neither end of line
    function automatic logic [7:0] rand_in_line();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        return (c == CH_NEWLINE) ? CH_SPACE : c;
    endfunction

    function automatic logic [7:0] bad_byte();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (char_is_num(c) || char_is_letter(c) || c == CH_EQUAL || c == CH_RBRACKET
               || c == CH_LBRACKET || c == CH_AT || c == CH_DOLLAR || c == CH_COMMA
               || c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_SEMI
               || c == CH_NEWLINE)
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    // One source line, mostly well formed, ended by newline or NUL
    function automatic void gen_line(input int line_no);
        int         n_tok;
        int         i;
        int         j;
        int         k;
        int         n_rest;
        logic [7:0] c;
        logic       line_done;
        if (line_no == 4) begin
            // identifier longer than the length counter
            add_ch("L");
            repeat (299) add_ch(rand_word_char());
        end else if (line_no == 9) begin
            repeat (280) add_ch(rand_digit());
        end else if (line_no == 15) begin
            // column pinned at its limit
            repeat (260) add_ch(CH_SPACE);
            add_ch(CH_EQUAL);
            add_ch(CH_AT);
        end else if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) add_ch(8'($urandom_range(0, 255)));
        end else begin
            line_done = 1'b0;
            n_tok     = $urandom_range(1, 8);
            for (i = 0; i < n_tok && !line_done; i++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        add_ch(($urandom_range(0, 3) == 0) ? "r" : CH_REG);
                        add_ch(rand_digit());
                        if ($urandom_range(0, 4) == 0)
                            add_ch(rand_word_char());
                    end
                    1, 2: begin
                        // keyword, near misses included
                        k = $urandom_range(0, NUM_KW - 1);
                        c = KW_FIRST[k];
                        if ($urandom_range(0, 5) == 0)
                            c = c | 8'h20;
                        add_ch(c);
                        n_rest = KW_REST_LEN[k];
                        if ($urandom_range(0, 5) == 0)
                            n_rest = n_rest - 1;
                        for (j = 0; j < n_rest; j++)
                            add_ch(KW_REST[k][j] | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
                        if ($urandom_range(0, 5) == 0)
                            add_ch(rand_word_char());
                    end
                    3: begin
                        add_ch(rand_letter());
                        repeat ($urandom_range(0, 8)) add_ch(rand_word_char());
                    end
                    4: repeat ($urandom_range(1, 6)) add_ch(rand_digit());
                    5: add_ch(PUNCT[$urandom_range(0, 5)]);
                    6: repeat ($urandom_range(1, 3)) add_ch(BLANKS[$urandom_range(0, 2)]);
                    7: begin
                        add_ch(CH_SEMI);
                        repeat ($urandom_range(0, 6)) add_ch(rand_in_line());
                        line_done = 1'b1;
                    end
                    8: begin
                        add_ch(bad_byte());
                        repeat ($urandom_range(0, 4)) add_ch(rand_in_line());
                        line_done = 1'b1;
                    end
                    default: add_ch(rand_in_line());
                endcase
                if (!line_done && $urandom_range(0, 3) != 0)
                    add_ch(SEPS[$urandom_range(0, 3)]);
            end
        end
        add_ch(($urandom_range(0, 4) == 0) ? CH_NUL : CH_NEWLINE);
    endfunction

    // Sender: directed table, then random lines
    initial begin : source_side
        int i;
        int line_no;
        src_if.valid <= 1'b0;
        src_if.ch    <= 8'd0;
        req_now      <= '0;
        for (i = 0; i < DIR_ROWS; i++)
            src_text.push_back(DIRECTED_TEXT[i]);
        line_no = 0;
        while (src_text.size() < TEXT_TARGET) begin
            gen_line(line_no);
            line_no++;
        end
        src_total = src_text.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < src_total; i++) begin
            if (i == DRAIN_AT) begin
                // let every token come out before going on
                src_if.valid <= 1'b0;
                @(posedge i_clk);
                while (tokens_due.size() != 0) @(posedge i_clk);
            end else if (i < src_total - TAIL_CALM && !(i >= QUIET_LO && i < QUIET_HI)
                         && $urandom_range(0, 4) == 0) begin
                src_if.valid <= 1'b0;
                src_if.ch    <= 8'($urandom_range(0, 255));
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            src_if.valid <= 1'b1;
            src_if.ch    <= src_text[i].ch;
            req_now      <= src_text[i];
            @(posedge i_clk);
            while (!src_if.ready) @(posedge i_clk);
        end
        src_if.valid <= 1'b0;

        @(posedge i_clk);
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Receiver: random stalls, one long hold-off, steady at the end
    initial begin : sink_side
        logic held;
        held = 1'b0;
        tok_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && accepted_cnt >= HOLD_AT) begin
                held = 1'b1;
                tok_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (accepted_cnt < src_total - TAIL_CALM
                         && !(accepted_cnt >= QUIET_LO && accepted_cnt < QUIET_HI)
                         && $urandom_range(0, 4) == 0) begin
                tok_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                tok_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Accepted byte request: predict its tokens
    always @(posedge i_clk) begin : src_watch
        t_tok t;
        if (i_rst_n && src_if.valid && src_if.ready) begin
            tokenize_byte(src_if.ch);
            accepted_cnt <= accepted_cnt + 1;
            if (req_now.typed) begin
                t.kind      = req_now.kind;
                t.start_col = req_now.col;
                t.tok_len   = req_now.len;
                t.last      = 1'b1;
                tokens_due.push_back(t);
            end else begin
                foreach (byte_tokens[k])
                    tokens_due.push_back(byte_tokens[k]);
            end
        end
    end

    // Accepted token request: compare with the oldest one due
    always @(posedge i_clk) begin : tok_watch
        t_tok want;
        if (i_rst_n && tok_if.valid && tok_if.ready) begin
            if (tokens_due.size() == 0) begin
                $display("%0t: unexpected token kind=%0d col=%0d len=%0d last=%0b", $time,
                         tok_if.kind, tok_if.start_col, tok_if.tok_len, tok_if.last);
                mismatch_cnt++;
            end else begin
                want = tokens_due.pop_front();
                if (tok_if.kind !== want.kind || tok_if.start_col !== want.start_col
                    || tok_if.tok_len !== want.tok_len || tok_if.last !== want.last) begin
                    $display("%0t: token mismatch: expected kind=%0d col=%0d len=%0d last=%0b",
                             $time, want.kind, want.start_col, want.tok_len, want.last);
                    $display("%0t:                 actual   kind=%0d col=%0d len=%0d last=%0b",
                             $time, tok_if.kind, tok_if.start_col, tok_if.tok_len,
                             tok_if.last);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Hang guard
    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

@@ sim.f @@
hdl/altok_pkg.sv
hdl/altok_if.sv
hdl/assembly_line_tokenizer.sv
hdl/altok_checker.sv
tb/tb_assembly_line_tokenizer.sv
